### rtl/raster_set_boundary_marker_top_defines.svh
// ----------------------------------------------------------------------------
// Boundary marker assertion macros
// Shared property wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RASTER_SET_BOUNDARY_MARKER_TOP_DEFINES_SVH
`define RASTER_SET_BOUNDARY_MARKER_TOP_DEFINES_SVH

// same-cycle implication
`define RSBM_ASSERT_IMPL(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSBM_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rsbm_pkg.sv
// ----------------------------------------------------------------------------
// Boundary marker package
// Field widths, reset values, register indexes and inter-module types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsbm_pkg;

  localparam int unsigned POS_W      = 12;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;

  localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 13'd480;
  localparam logic [COUNT_W-1:0] RST_ITER_LIMIT   = 32'd1048576;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_ITER_LIMIT   = 2'd2
  } cfg_reg_e;

  // line store write request; columns travel as separate ports
  typedef struct packed {
    logic in_we;      // inside flag of current column
    logic in_val;
    logic left_we;    // pending edge of column to the left
    logic left_val;
    logic cur_we;     // pending edge of current column
    logic cur_val;
  } ls_wr_t;

  typedef struct packed {
    logic up_inside;
    logic up_pend;
  } ls_rd_t;

  typedef struct packed {
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic             is_edge;
    logic             frame_end;
    logic             last_of_run;
  } res_t;

endpackage

### rtl/raster_set_boundary_marker_top.sv
// ----------------------------------------------------------------------------
// Boundary marker top level
// Marks 4-connected inner boundary pixels of a raster frame of counts.
// ----------------------------------------------------------------------------
// Input channel: one iteration count per beat, raster order. Output channel:
// one result per beat (column, row, edge flag, frame end, last of run).
// An item yields up to three results; the pixel above it on rows past the
// first, plus the left pixel and the final pixel on the last row.
// Config port: cfg_index_i selects frame_width, frame_height or
// iteration_limit; always ready; write only while the block is idle.
// Path: an item is held in the stage register, then its results enter a
// four-entry output queue, from which the first can be taken.
// Throughput: one item per cycle while each item gives at most one result
// and the output is not stalled; on the last row the single output port sets
// the pace. The one-bit line store takes one read and one write per cycle.
// Reset: position returns to column 0, row 0, registers take their defaults,
// queue empties; the line store is not cleared and needs no sweep.
// Stall: a stalled output holds its beat; the queue absorbs up to three more
// results, then the input channel stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "raster_set_boundary_marker_top_defines.svh"

module raster_set_boundary_marker_top #(
  parameter int unsigned MAX_WIDTH  = rsbm_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = rsbm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rsbm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rsbm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rsbm_pkg::COUNT_W-1:0]      iteration_count_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rsbm_pkg::POS_W-1:0]        pixel_column_o,
  output logic [rsbm_pkg::POS_W-1:0]        pixel_row_o,
  output logic                              is_edge_o,
  output logic                              frame_end_o,
  output logic                              last_of_run_o
);
  import rsbm_pkg::*;

  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = FIFO_AW + 1;

  // configuration
  logic [DIM_W-1:0]   frame_width_q, frame_height_q;
  logic [COUNT_W-1:0] iteration_limit_q;
  logic [COL_W-1:0]   width_last;
  logic [ROW_W-1:0]   height_last;

  // position of next pixel
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             pos_last_col, pos_last_row;
  logic             in_accept;

  // stage register
  logic             s1_valid_q, s1_valid_d;
  logic [COL_W-1:0] s1_x_q;
  logic [ROW_W-1:0] s1_y_q;
  logic             s1_last_col_q, s1_last_row_q, s1_cur_q;

  logic left_inside_q, left_inside_d, left_pend_q, left_pend_d;

  ls_wr_t ls_wr;
  ls_rd_t ls_rd;

  logic             x_nz, y_nz, v_a, v_b, v_c, cur_pend, left_res, fire;
  logic [1:0]       n_res;
  logic [ROW_W-1:0] y_m1;
  logic [COL_W-1:0] x_m1;
  res_t             res_a, res_b, res_c;

  // output queue
  res_t               fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, idx_b, idx_c;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               pop;
  res_t               head;

  // ---------------- configuration port ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q     <= RST_FRAME_WIDTH;
      frame_height_q    <= RST_FRAME_HEIGHT;
      iteration_limit_q <= RST_ITER_LIMIT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  frame_width_q     <= cfg_data_i[DIM_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q    <= cfg_data_i[DIM_W-1:0];
        CFG_ITER_LIMIT:   iteration_limit_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // last index after clamping zero to one and large values to the maximum
  always_comb begin
    if (frame_width_q == '0) begin
      width_last = '0;
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      width_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      width_last = COL_W'(frame_width_q - DIM_W'(1));
    end
    if (frame_height_q == '0) begin
      height_last = '0;
    end else if (32'(frame_height_q) > MAX_HEIGHT) begin
      height_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      height_last = ROW_W'(frame_height_q - DIM_W'(1));
    end
  end

  // ---------------- input side ----------------
  assign in_stall_o   = s1_valid_q && !fire;
  assign in_accept    = in_valid_i && !in_stall_o;
  assign pos_last_col = (col_q >= width_last);
  assign pos_last_row = (row_q >= height_last);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_accept) begin
      if (pos_last_col) begin
        col_d = '0;
        row_d = pos_last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
    s1_valid_d = in_accept ? 1'b1 : (fire ? 1'b0 : s1_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_x_q        <= col_q;
      s1_y_q        <= row_q;
      s1_last_col_q <= pos_last_col;
      s1_last_row_q <= pos_last_row;
      s1_cur_q      <= (iteration_count_i == iteration_limit_q);
    end
  end

  rsbm_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i    (clk_i),
    .rd_en_i  (in_accept),
    .rd_col_i (col_q),
    .wr_col_i (s1_x_q),
    .wr_i     (ls_wr),
    .rd_o     (ls_rd)
  );

  // ---------------- edge decisions ----------------
  always_comb begin
    x_nz     = (s1_x_q != '0);
    y_nz     = (s1_y_q != '0);
    x_m1     = s1_x_q - COL_W'(1);
    y_m1     = s1_y_q - ROW_W'(1);
    cur_pend = s1_cur_q && ((x_nz && !left_inside_q) || (y_nz && !ls_rd.up_inside));
    left_res = left_pend_q || (left_inside_q && !s1_cur_q);
    v_a      = y_nz;
    v_b      = x_nz && s1_last_row_q;
    v_c      = s1_last_col_q && s1_last_row_q;
    n_res    = {1'b0, v_a} + {1'b0, v_b} + {1'b0, v_c};
    fire     = s1_valid_q && ((cnt_q + CNT_W'(n_res)) <= CNT_W'(FIFO_DEPTH));

    res_a.column      = POS_W'(s1_x_q);
    res_a.row         = POS_W'(y_m1);
    res_a.is_edge     = ls_rd.up_pend || (ls_rd.up_inside && !s1_cur_q);
    res_a.frame_end   = 1'b0;
    res_a.last_of_run = !v_b && !v_c;

    res_b.column      = POS_W'(x_m1);
    res_b.row         = POS_W'(s1_y_q);
    res_b.is_edge     = left_res;
    res_b.frame_end   = 1'b0;
    res_b.last_of_run = !v_c;

    res_c.column      = POS_W'(s1_x_q);
    res_c.row         = POS_W'(s1_y_q);
    res_c.is_edge     = cur_pend;
    res_c.frame_end   = 1'b1;
    res_c.last_of_run = 1'b1;

    ls_wr.in_we    = fire;
    ls_wr.in_val   = s1_cur_q;
    ls_wr.left_we  = fire && x_nz && !s1_last_row_q;
    ls_wr.left_val = left_res;
    ls_wr.cur_we   = fire && s1_last_col_q && !s1_last_row_q;
    ls_wr.cur_val  = cur_pend;

    left_inside_d = left_inside_q;
    left_pend_d   = left_pend_q;
    if (fire) begin
      left_inside_d = s1_last_col_q ? 1'b0 : s1_cur_q;
      left_pend_d   = s1_last_col_q ? 1'b0 : cur_pend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_inside_q <= 1'b0;
      left_pend_q   <= 1'b0;
    end else begin
      left_inside_q <= left_inside_d;
      left_pend_q   <= left_pend_d;
    end
  end

  // ---------------- output queue ----------------
  always_comb begin
    pop      = out_valid_o && !out_stall_i;
    idx_b    = wr_ptr_q + FIFO_AW'(v_a);
    idx_c    = wr_ptr_q + FIFO_AW'({1'b0, v_a} + {1'b0, v_b});
    wr_ptr_d = fire ? wr_ptr_q + FIFO_AW'(n_res) : wr_ptr_q;
    rd_ptr_d = rd_ptr_q + FIFO_AW'(pop);
    cnt_d    = cnt_q + (fire ? CNT_W'(n_res) : '0) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (v_a) fifo_q[wr_ptr_q] <= res_a;
      if (v_b) fifo_q[idx_b] <= res_b;
      if (v_c) fifo_q[idx_c] <= res_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign head           = fifo_q[rd_ptr_q];
  assign out_valid_o    = (cnt_q != '0);
  assign pixel_column_o = head.column;
  assign pixel_row_o    = head.row;
  assign is_edge_o      = head.is_edge;
  assign frame_end_o    = head.frame_end;
  assign last_of_run_o  = head.last_of_run;

  // ---------------- assertions ----------------
  `RSBM_ASSERT_IMPL(a_stage_drains, in_accept && s1_valid_q, fire, "stage overwritten before it drained")
  `RSBM_ASSERT_IMPL(a_frame_end_last, out_valid_o && frame_end_o, last_of_run_o, "frame end beat not last of its run")
  `RSBM_ASSERT_NEXT(a_frame_wrap, in_accept && pos_last_col && pos_last_row, (col_q == '0) && (row_q == '0), "position did not return to origin after final pixel")

endmodule

### rtl/rsbm_line_store.sv
// ----------------------------------------------------------------------------
// Boundary marker line store
// One-row memory of inside flags and pending edge bits, registered read with
// write-through, pending bits split into even and odd column banks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsbm_line_store #(
  parameter int unsigned MAX_WIDTH = rsbm_pkg::DEF_MAX_WIDTH,
  localparam int unsigned COL_W    = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [COL_W-1:0] rd_col_i,
  input  logic [COL_W-1:0] wr_col_i,
  input  rsbm_pkg::ls_wr_t wr_i,
  output rsbm_pkg::ls_rd_t rd_o
);
  import rsbm_pkg::*;

  localparam int unsigned HALF_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int unsigned HALF_W     = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;

  logic inside_mem    [MAX_WIDTH];
  logic pend_even_mem [HALF_DEPTH];
  logic pend_odd_mem  [HALF_DEPTH];

  logic [COL_W-1:0]  wr_col_m1;
  logic [HALF_W-1:0] even_wr_idx, odd_wr_idx, rd_idx;
  logic              even_we, even_wd, odd_we, odd_wd;
  logic              inside_rd_q, even_rd_q, odd_rd_q, rd_odd_q;

  // columns x-1 and x always land in different banks
  always_comb begin
    wr_col_m1 = wr_col_i - COL_W'(1);
    rd_idx    = HALF_W'(rd_col_i >> 1);
    if (wr_col_i[0]) begin
      even_we     = wr_i.left_we;
      even_wd     = wr_i.left_val;
      even_wr_idx = HALF_W'(wr_col_m1 >> 1);
      odd_we      = wr_i.cur_we;
      odd_wd      = wr_i.cur_val;
      odd_wr_idx  = HALF_W'(wr_col_i >> 1);
    end else begin
      even_we     = wr_i.cur_we;
      even_wd     = wr_i.cur_val;
      even_wr_idx = HALF_W'(wr_col_i >> 1);
      odd_we      = wr_i.left_we;
      odd_wd      = wr_i.left_val;
      odd_wr_idx  = HALF_W'(wr_col_m1 >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.in_we) inside_mem[wr_col_i] <= wr_i.in_val;
    if (even_we)    pend_even_mem[even_wr_idx] <= even_wd;
    if (odd_we)     pend_odd_mem[odd_wr_idx] <= odd_wd;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      inside_rd_q <= (wr_i.in_we && (wr_col_i == rd_col_i)) ? wr_i.in_val
                                                           : inside_mem[rd_col_i];
      even_rd_q   <= (even_we && (even_wr_idx == rd_idx)) ? even_wd
                                                          : pend_even_mem[rd_idx];
      odd_rd_q    <= (odd_we && (odd_wr_idx == rd_idx)) ? odd_wd
                                                        : pend_odd_mem[rd_idx];
      rd_odd_q    <= rd_col_i[0];
    end
  end

  assign rd_o.up_inside = inside_rd_q;
  assign rd_o.up_pend   = rd_odd_q ? odd_rd_q : even_rd_q;

endmodule

### tb/raster_set_boundary_marker_top_tb.sv
// ----------------------------------------------------------------------------
// Boundary marker testbench
// Streams iteration counts through the marker and predicts, per accepted
// pixel, the results it releases (pixel above, pixel to the left, final
// pixel). Results are checked in order against the prediction. Runs directed
// frames, random frames with mid-frame register changes, and frames opened
// with oversized and full-size registers, under random input gaps and output
// stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module raster_set_boundary_marker_top_tb;

  import rsbm_pkg::*;

  localparam int unsigned CLK_HALF        = 2;
  localparam int unsigned RESET_CYCLES    = 11;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned RANDOM_ITEMS    = 500;
  localparam int unsigned BIG_FRAME_ITEMS = 40;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned MAX_W           = DEF_MAX_WIDTH;
  localparam int unsigned MAX_H           = DEF_MAX_HEIGHT;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  class boundary_scoreboard;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [COUNT_W-1:0] limit_reg;
    bit                 line_inside[MAX_W];
    bit                 line_pending[MAX_W];
    bit                 prev_inside;
    bit                 prev_pending;
    int unsigned        col_pos;
    int unsigned        row_pos;
    res_t               awaited[$];
    int unsigned        errors;

    function new();
      width_reg    = RST_FRAME_WIDTH;
      height_reg   = RST_FRAME_HEIGHT;
      limit_reg    = RST_ITER_LIMIT;
      prev_inside  = 1'b0;
      prev_pending = 1'b0;
      col_pos      = 0;
      row_pos      = 0;
      errors       = 0;
    endfunction

    function int unsigned dim_of(logic [DIM_W-1:0] v, int unsigned cap);
      if (v == '0) return 1;
      if (v > cap) return cap;
      return 32'(v);
    endfunction

    function int unsigned eff_width();
      return dim_of(width_reg, MAX_W);
    endfunction

    function int unsigned eff_height();
      return dim_of(height_reg, MAX_H);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FRAME_WIDTH:  width_reg = data[DIM_W-1:0];
        CFG_FRAME_HEIGHT: height_reg = data[DIM_W-1:0];
        CFG_ITER_LIMIT:   limit_reg = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function res_t pixel_result(int unsigned x, int unsigned y, bit e, bit fend);
      res_t r;
      r.column      = x[POS_W-1:0];
      r.row         = y[POS_W-1:0];
      r.is_edge     = e;
      r.frame_end   = fend;
      r.last_of_run = 1'b0;
      return r;
    endfunction

    // advances the raster position by one pixel and queues what it releases
    function void mark_pixel(logic [COUNT_W-1:0] count);
      int unsigned w, h, x, y;
      bit cur, up_in, last_col, last_row, cur_pend, lp;
      res_t batch[3];
      int n;
      w = eff_width();
      h = eff_height();
      x = col_pos;
      y = row_pos;
      n = 0;
      if (x >= MAX_W) x = MAX_W - 1;
      if (y >= MAX_H) y = MAX_H - 1;
      last_col = (x + 1 >= w);
      last_row = (y + 1 >= h);
      cur   = (count == limit_reg);
      up_in = line_inside[x];
      if (y > 0) begin
        batch[n] = pixel_result(x, y - 1, line_pending[x] || (up_in && !cur), 1'b0);
        n++;
      end
      cur_pend = cur && ((x > 0 && !prev_inside) || (y > 0 && !up_in));
      if (x > 0) begin
        lp = prev_pending || (prev_inside && !cur);
        if (last_row) begin
          batch[n] = pixel_result(x - 1, y, lp, 1'b0);
          n++;
        end else begin
          line_pending[x - 1] = lp;
        end
      end
      line_inside[x] = cur;
      if (last_col) begin
        if (last_row) begin
          batch[n] = pixel_result(x, y, cur_pend, 1'b1);
          n++;
        end else begin
          line_pending[x] = cur_pend;
        end
        prev_inside  = 1'b0;
        prev_pending = 1'b0;
        col_pos      = 0;
        row_pos      = last_row ? 0 : y + 1;
      end else begin
        prev_inside  = cur;
        prev_pending = cur_pend;
        col_pos      = x + 1;
        row_pos      = y;
      end
      if (n > 0) batch[n - 1].last_of_run = 1'b1;
      for (int k = 0; k < n; k++) awaited.push_back(batch[k]);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        flag($sformatf("unexpected result: col %0d row %0d edge %0b end %0b last %0b",
                       got.column, got.row, got.is_edge, got.frame_end, got.last_of_run));
        return;
      end
      want = awaited.pop_front();
      if (got.column !== want.column || got.row !== want.row ||
          got.is_edge !== want.is_edge || got.frame_end !== want.frame_end ||
          got.last_of_run !== want.last_of_run) begin
        flag($sformatf({"result mismatch: expected col %0d row %0d edge %0b end %0b ",
                        "last %0b, got col %0d row %0d edge %0b end %0b last %0b"},
                       want.column, want.row, want.is_edge, want.frame_end,
                       want.last_of_run, got.column, got.row, got.is_edge,
                       got.frame_end, got.last_of_run));
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall_o;
  logic [COUNT_W-1:0]    iteration_count = '0;
  logic                  out_valid_o;
  logic                  out_stall = 1'b0;
  logic [POS_W-1:0]      pixel_column_o;
  logic [POS_W-1:0]      pixel_row_o;
  logic                  is_edge_o;
  logic                  frame_end_o;
  logic                  last_of_run_o;

  boundary_scoreboard sb = new();
  int unsigned        idle_chance = 0;
  int unsigned        stall_run = 0;
  int unsigned        quiet_cycles = 0;
  int unsigned        random_items = 0;

  raster_set_boundary_marker_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .iteration_count_i (iteration_count),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .pixel_column_o    (pixel_column_o),
    .pixel_row_o       (pixel_row_o),
    .is_edge_o         (is_edge_o),
    .frame_end_o       (frame_end_o),
    .last_of_run_o     (last_of_run_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // random output stall bursts
  always @(posedge clk_i) begin
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else if (idle_chance != 0 && $urandom_range(1, 100) <= idle_chance) begin
      out_stall <= 1'b1;
      stall_run <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      sb.check_result({pixel_column_o, pixel_row_o, is_edge_o, frame_end_o, last_of_run_o});
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [COUNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return sb.limit_reg;
    if (r < 72) return sb.limit_reg ^ (32'd1 << $urandom_range(0, 31));
    return $urandom;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return RST_ITER_LIMIT;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 1;
    if (r < 80) return $urandom_range(2, 6);
    return $urandom_range(7, 24);
  endfunction

  // register word for a size; 1 is sometimes sent as 0, upper bits sometimes carry junk
  function automatic logic [CFG_DATA_W-1:0] dim_word(int unsigned n);
    logic [CFG_DATA_W-1:0] v;
    v = (n == 1 && $urandom_range(0, 3) == 0) ? '0 : n;
    if ($urandom_range(0, 3) == 0) v[CFG_DATA_W-1:DIM_W] = (CFG_DATA_W-DIM_W)'($urandom);
    return v;
  endfunction

  task automatic send_pixel(input logic [COUNT_W-1:0] count);
    int unsigned gap;
    if (idle_chance != 0 && $urandom_range(1, 100) <= idle_chance) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    iteration_count <= count;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.mark_pixel(count);
  endtask

  // caller lowers cfg_valid after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned n);
    repeat (n) begin
      send_pixel(pick_count());
      random_items++;
    end
    settle();
  endtask

  // mid-frame: width may only shrink, and a single-row frame keeps its height
  // on row 0, so no line-store entry is read before it is written
  task automatic reconfigure();
    bit mid, wrote;
    int unsigned cur_w, cur_h, nw;
    mid   = (sb.col_pos != 0) || (sb.row_pos != 0);
    cur_w = sb.eff_width();
    cur_h = sb.eff_height();
    wrote = 1'b0;
    if ($urandom_range(0, 2) != 0) begin
      nw = mid ? $urandom_range(1, (cur_w < 6) ? cur_w : 6) : pick_dim();
      write_reg(CFG_FRAME_WIDTH, dim_word(nw));
      wrote = 1'b1;
    end
    if ($urandom_range(0, 2) != 0 && !(mid && sb.row_pos == 0 && cur_h == 1)) begin
      write_reg(CFG_FRAME_HEIGHT, dim_word(pick_dim()));
      wrote = 1'b1;
    end
    if (!wrote || $urandom_range(0, 1) != 0) write_reg(CFG_ITER_LIMIT, pick_limit());
    if ($urandom_range(0, 9) == 0) write_reg(CFG_SPARE_IDX, $urandom);
    cfg_valid <= 1'b0;
  endtask

  // a 1x1 size closes an open frame on its next pixel; the large frame is
  // left open and later phases shrink it
  task automatic big_frame(input logic [CFG_DATA_W-1:0] wdata,
                           input logic [CFG_DATA_W-1:0] hdata);
    if (sb.col_pos != 0 || sb.row_pos != 0) begin
      write_reg(CFG_FRAME_WIDTH, 32'd1);
      write_reg(CFG_FRAME_HEIGHT, 32'd1);
      cfg_valid <= 1'b0;
      run_phase(1);
    end
    write_reg(CFG_FRAME_WIDTH, wdata);
    write_reg(CFG_FRAME_HEIGHT, hdata);
    write_reg(CFG_ITER_LIMIT, pick_limit());
    cfg_valid <= 1'b0;
    run_phase(BIG_FRAME_ITEMS);
  endtask

  initial begin
    int unsigned phase, span;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_chance = 15;

    // reset sizes and limit, part of a first row
    send_pixel(RST_ITER_LIMIT);
    send_pixel(RST_ITER_LIMIT);
    send_pixel('0);
    settle();

    // width shrinks past the current column inside the frame
    write_reg(CFG_FRAME_WIDTH, 32'd3);
    write_reg(CFG_FRAME_HEIGHT, 32'd3);
    write_reg(CFG_ITER_LIMIT, '1);
    cfg_valid <= 1'b0;
    send_pixel('1);
    send_pixel('1);
    send_pixel('1);
    send_pixel('1);
    send_pixel('1);
    send_pixel('0);
    send_pixel('1);
    settle();

    // zero sizes act as one: single-pixel frames
    write_reg(CFG_FRAME_WIDTH, 32'hFFFF_E000);
    write_reg(CFG_FRAME_HEIGHT, 32'h0000_2000);
    write_reg(CFG_ITER_LIMIT, '0);
    cfg_valid <= 1'b0;
    send_pixel('0);
    send_pixel('1);
    send_pixel('0);
    settle();

    write_reg(CFG_FRAME_WIDTH, 32'd2);
    write_reg(CFG_FRAME_HEIGHT, 32'd2);
    write_reg(CFG_ITER_LIMIT, 32'h8000_0000);
    write_reg(CFG_SPARE_IDX, 32'hA5A5_5A5A);
    cfg_valid <= 1'b0;
    repeat (4) send_pixel(32'h8000_0000);
    send_pixel(32'h8000_0000);
    send_pixel('0);
    send_pixel(32'h7FFF_FFFF);
    send_pixel(32'h8000_0000);
    settle();

    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (random_items + 100 >= RANDOM_ITEMS) begin
        idle_chance = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: idle_chance = 0;
          1: idle_chance = 8;
          default: idle_chance = 20;
        endcase
      end
      if (phase == 5) begin
        big_frame(32'hFFFF_FFFF, 32'h0000_2001);
      end else if (phase == 10) begin
        big_frame(32'd1, 32'd4096);
      end else begin
        reconfigure();
        span = sb.eff_width() * sb.eff_height() * 2 + 2;
        run_phase($urandom_range(1, (span > 40) ? 40 : span));
      end
      phase++;
    end

    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
